>>> design/csai_pkg.sv
// Shared types and constants for the cardinal spline axis interpolator.
package csai_pkg;

    localparam int VALUE_W = 32;
    localparam int TAG_W   = 2;
    localparam int STAGES  = 7;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [TAG_W-1:0]          t_tag;

endpackage

>>> design/cardinal_spline_axis_interp_unit.sv
// Top level: seven-stage pipelined cardinal spline interpolation of one axis.
//
// Input channel (i_valid/o_ready) takes one item: four signed Q16.16 control
// values, a fraction t in unsigned Q1.F (values above 1.0 clamp to 1.0) and an
// axis tag. Output channel (o_valid/i_ready) returns the interpolated value,
// saturated to signed Q16.16, with the tag copied through.
// The tension register (Q2.F, reset 0.5 = Catmull-Rom) is written through
// i_cfg_valid/o_cfg_ready/i_cfg_data; write it only while the block is idle.
// An accepted item passes through seven register stages, the first loaded at
// the accepting edge, before o_valid rises. Throughput: one item per cycle
// while i_ready does not stall the output, through the chain of
// registered multiplies (t^2, t^3, weight products, control products) and
// the two-stage final sum.
// Each stage advances when it is empty or the stage after it moves, so a
// stall on i_ready fills empty stages first and input stays accepted until
// the pipeline is full; nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and loads tension 0.5.
module cardinal_spline_axis_interp_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [FRACTION_BITS+1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  csai_pkg::t_value        i_prev_value,
    input  csai_pkg::t_value        i_start_value,
    input  csai_pkg::t_value        i_end_value,
    input  csai_pkg::t_value        i_next_value,
    input  logic [FRACTION_BITS:0]  i_fraction,
    input  csai_pkg::t_tag          i_axis_tag,
    output logic                    o_valid,
    input  logic                    i_ready,
    output csai_pkg::t_value        o_value,
    output csai_pkg::t_tag          o_axis_out
);

    localparam int F    = FRACTION_BITS;
    localparam int ONE  = 1 << F;
    localparam int HALF = 1 << (F - 1);
    localparam int NS   = csai_pkg::STAGES;
    localparam int WW   = F + 6;
    localparam int PW   = F + 38;
    localparam int SW   = F + 40;
    localparam int VW   = csai_pkg::VALUE_W;

    logic [F+1:0]  r_tension;
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    // stage 0
    logic [F:0]               r_s0_t;
    logic [2*F+1:0]           r_s0_tt;
    csai_pkg::t_value         r_s0_p [4];
    csai_pkg::t_tag           r_s0_tag;
    // stage 1
    logic [F:0]               r_s1_t;
    logic [F:0]               r_s1_t2;
    logic [2*F+1:0]           r_s1_t2t;
    csai_pkg::t_value         r_s1_p [4];
    csai_pkg::t_tag           r_s1_tag;
    // stage 2
    logic signed [2*F+6:0]    r_s2_m0;
    logic signed [2*F+5:0]    r_s2_ma;
    logic signed [2*F+5:0]    r_s2_mb;
    logic signed [2*F+4:0]    r_s2_m3;
    csai_pkg::t_value         r_s2_p [4];
    csai_pkg::t_tag           r_s2_tag;
    // stage 3
    logic signed [WW-1:0]     r_s3_w [4];
    csai_pkg::t_value         r_s3_p [4];
    csai_pkg::t_tag           r_s3_tag;
    // stage 4
    logic signed [PW-1:0]     r_s4_m [4];
    csai_pkg::t_tag           r_s4_tag;
    // stage 5
    logic signed [SW-1:0]     r_s5_s01;
    logic signed [SW-1:0]     r_s5_s23;
    csai_pkg::t_tag           r_s5_tag;
    // stage 6
    csai_pkg::t_value         r_s6_value;
    csai_pkg::t_tag           r_s6_tag;

    logic [F:0]               t_clamp;
    logic [2*F+1:0]           tt_rnd;
    logic [F:0]               t2;
    logic [2*F+1:0]           t2t_rnd;
    logic [F:0]               t3;
    logic signed [F+2:0]      s_sgn;
    logic signed [F+3:0]      d0;
    logic signed [F+3:0]      c1;
    logic signed [F+3:0]      c2;
    logic signed [F+1:0]      d3;
    logic signed [2*F+7:0]    m0_rnd;
    logic signed [2*F+7:0]    m1_rnd;
    logic signed [2*F+7:0]    m3_rnd;
    logic signed [WW-1:0]     w0;
    logic signed [WW-1:0]     w1;
    logic signed [WW-1:0]     w3;
    logic signed [SW:0]       acc;
    logic signed [40:0]       acc_q;
    logic                     acc_ovf;
    csai_pkg::t_value         sat_value;

    // stall chain: a stage loads when empty or when the next stage moves
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready     = w_en[0];
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[NS-1];
    assign o_value     = r_s6_value;
    assign o_axis_out  = r_s6_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_tension <= (F+2)'(HALF);
        end else begin
            if (i_cfg_valid) begin
                r_tension <= i_cfg_data;
            end
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        t_clamp   = (i_fraction > (F+1)'(ONE)) ? (F+1)'(ONE) : i_fraction;
        tt_rnd    = r_s0_tt + (2*F+2)'(HALF);
        t2        = tt_rnd[2*F:F];
        t2t_rnd   = r_s1_t2t + (2*F+2)'(HALF);
        t3        = t2t_rnd[2*F:F];
        s_sgn     = $signed({1'b0, r_tension});
        d0        = $signed({2'b00, r_s1_t2, 1'b0}) - $signed({3'b000, r_s1_t})
                  - $signed({3'b000, t3});
        c1        = $signed((F+4)'(2*ONE)) - $signed({2'b00, r_tension});
        c2        = $signed({2'b00, r_tension}) - $signed((F+4)'(3*ONE));
        d3        = $signed({1'b0, t3}) - $signed({1'b0, r_s1_t2});
        m0_rnd    = (2*F+8)'(r_s2_m0) + (2*F+8)'(HALF);
        m1_rnd    = (2*F+8)'(r_s2_ma) + (2*F+8)'(r_s2_mb) + (2*F+8)'(HALF);
        m3_rnd    = (2*F+8)'(r_s2_m3) + (2*F+8)'(HALF);
        w0        = m0_rnd[2*F+5:F];
        w1        = m1_rnd[2*F+5:F] + WW'(ONE);
        w3        = m3_rnd[2*F+5:F];
        acc       = (SW+1)'(r_s5_s01) + (SW+1)'(r_s5_s23);
        acc_q     = acc[F+40:F];
        acc_ovf   = !((&acc_q[40:VW-1]) || !(|acc_q[40:VW-1]));
        sat_value = acc_q[VW-1:0];
        if (acc_ovf) begin
            sat_value = acc_q[40] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_t    <= t_clamp;
            r_s0_tt   <= t_clamp * t_clamp;
            r_s0_p[0] <= i_prev_value;
            r_s0_p[1] <= i_start_value;
            r_s0_p[2] <= i_end_value;
            r_s0_p[3] <= i_next_value;
            r_s0_tag  <= i_axis_tag;
        end
        if (w_en[1]) begin
            r_s1_t   <= r_s0_t;
            r_s1_t2  <= t2;
            r_s1_t2t <= t2 * r_s0_t;
            r_s1_p   <= r_s0_p;
            r_s1_tag <= r_s0_tag;
        end
        if (w_en[2]) begin
            r_s2_m0  <= s_sgn * d0;
            r_s2_ma  <= c1 * $signed({1'b0, t3});
            r_s2_mb  <= c2 * $signed({1'b0, r_s1_t2});
            r_s2_m3  <= s_sgn * d3;
            r_s2_p   <= r_s1_p;
            r_s2_tag <= r_s1_tag;
        end
        if (w_en[3]) begin
            r_s3_w[0] <= w0;
            r_s3_w[1] <= w1;
            r_s3_w[2] <= WW'(ONE) - w0 - w1 - w3;
            r_s3_w[3] <= w3;
            r_s3_p    <= r_s2_p;
            r_s3_tag  <= r_s2_tag;
        end
        if (w_en[4]) begin
            for (int i = 0; i < 4; i++) begin
                r_s4_m[i] <= r_s3_w[i] * r_s3_p[i];
            end
            r_s4_tag <= r_s3_tag;
        end
        if (w_en[5]) begin
            r_s5_s01 <= SW'(r_s4_m[0]) + SW'(r_s4_m[1]);
            r_s5_s23 <= SW'(r_s4_m[2]) + SW'(r_s4_m[3]) + SW'(HALF);
            r_s5_tag <= r_s4_tag;
        end
        if (w_en[6]) begin
            r_s6_value <= sat_value;
            r_s6_tag   <= r_s5_tag;
        end
    end

    // an empty slot anywhere in the pipeline means input can be taken
    a_ready_when_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld != '1) |-> o_ready)
        else $error("input blocked with an empty pipeline stage");

    // a held first stage keeps its item
    a_stage0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !w_en[1]) |=> r_vld[0])
        else $error("stalled item lost in first stage");

    // nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

>>> tb/sv/cardinal_spline_axis_interp_unit_test.sv
// Self-checking testbench for the cardinal spline axis interpolator: random and directed items.
module cardinal_spline_axis_interp_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FB        = 16;
    localparam longint ONE       = longint'(1) << FB;
    localparam int     PHASE_LEN = 275;
    localparam int     HOLD_LEN  = 300;

    typedef struct {
        csai_pkg::t_value prev_v;
        csai_pkg::t_value start_v;
        csai_pkg::t_value end_v;
        csai_pkg::t_value next_v;
        logic [FB:0]      frac;
        csai_pkg::t_tag   tag;
    } t_spline_item;

    typedef struct {
        csai_pkg::t_value value;
        csai_pkg::t_tag   axis;
    } t_spline_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic [FB+1:0]     cfg_data = '0;
    logic              cfg_ready;

    logic              in_valid = 1'b0;
    logic              in_ready;
    csai_pkg::t_value  in_prev = '0;
    csai_pkg::t_value  in_start = '0;
    csai_pkg::t_value  in_end = '0;
    csai_pkg::t_value  in_next = '0;
    logic [FB:0]       in_frac = '0;
    csai_pkg::t_tag    in_tag = '0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    csai_pkg::t_value  out_value;
    csai_pkg::t_tag    out_axis;

    t_spline_item      pending_items[$];
    t_spline_result    expected_points[$];
    logic [FB+1:0]     tension_q = 18'(1 << (FB - 1));
    int                send_idle_pct = 30;
    int                recv_idle_pct = 71;
    int                phase_no = -1;
    logic              rx_hold = 1'b0;
    int                errors = 0;

    cardinal_spline_axis_interp_unit #(
        .FRACTION_BITS(FB)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_prev_value  (in_prev),
        .i_start_value (in_start),
        .i_end_value   (in_end),
        .i_next_value  (in_next),
        .i_fraction    (in_frac),
        .i_axis_tag    (in_tag),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_value       (out_value),
        .o_axis_out    (out_axis)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint round_q(longint x);
        return (x + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    function automatic t_spline_result spline_point(logic [FB+1:0] s_reg, t_spline_item it);
        t_spline_result r;
        longint t, s, t2, t3, w0, w1, w2, w3, acc;
        t = longint'(it.frac);
        if (t > ONE) t = ONE;
        s = longint'(s_reg);
        t2 = round_q(t * t);
        t3 = round_q(t2 * t);
        w0 = round_q(s * (2 * t2 - t - t3));
        w1 = round_q((2 * ONE - s) * t3 + (s - 3 * ONE) * t2) + ONE;
        w3 = round_q(s * (t3 - t2));
        w2 = ONE - w0 - w1 - w3;
        acc = w0 * longint'(it.prev_v) + w1 * longint'(it.start_v)
            + w2 * longint'(it.end_v) + w3 * longint'(it.next_v);
        acc = round_q(acc);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        r.value = csai_pkg::t_value'(acc);
        r.axis  = it.tag;
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        errors++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_spline_item cur, nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                cur.prev_v  = in_prev;
                cur.start_v = in_start;
                cur.end_v   = in_end;
                cur.next_v  = in_next;
                cur.frac    = in_frac;
                cur.tag     = in_tag;
                expected_points.push_back(spline_point(tension_q, cur));
            end
            if (!in_valid || in_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    in_prev  <= nxt.prev_v;
                    in_start <= nxt.start_v;
                    in_end   <= nxt.end_v;
                    in_next  <= nxt.next_v;
                    in_frac  <= nxt.frac;
                    in_tag   <= nxt.tag;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_spline_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_points.size() == 0) begin
                    note_mismatch($sformatf("unexpected result value=%h axis=%0d",
                                            out_value, out_axis));
                end else begin
                    want = expected_points.pop_front();
                    if (out_value !== want.value)
                        note_mismatch($sformatf("value got %h want %h", out_value, want.value));
                    if (out_axis !== want.axis)
                        note_mismatch($sformatf("axis got %0d want %0d", out_axis, want.axis));
                end
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall while the sender keeps offering
    initial begin
        wait (phase_no == 4);
        repeat (40) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAIL cardinal_spline_axis_interp_unit");
        $finish;
    end

    task automatic add_item(csai_pkg::t_value p, csai_pkg::t_value s, csai_pkg::t_value e,
                            csai_pkg::t_value n, logic [FB:0] f, csai_pkg::t_tag tg);
        t_spline_item it;
        it.prev_v  = p;
        it.start_v = s;
        it.end_v   = e;
        it.next_v  = n;
        it.frac    = f;
        it.tag     = tg;
        pending_items.push_back(it);
    endtask

    function automatic csai_pkg::t_value rand_coord(int mode, csai_pkg::t_value base);
        case (mode)
            0: return base + csai_pkg::t_value'($urandom_range(0, 1 << 21))
                    - csai_pkg::t_value'(1 << 20);
            1: return csai_pkg::t_value'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return '0;
                    default: return csai_pkg::t_value'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic add_random_items(int count);
        int mode, pick;
        csai_pkg::t_value base;
        logic [FB:0] f;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            mode = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
            base = csai_pkg::t_value'($urandom);
            pick = $urandom_range(99);
            if (pick < 80)      f = 17'($urandom_range(0, 1 << FB));
            else if (pick < 90) f = $urandom_range(1) ? 17'(1 << FB) : '0;
            else                f = 17'($urandom_range((1 << FB) + 1, (1 << (FB + 1)) - 1));
            add_item(rand_coord(mode, base), rand_coord(mode, base), rand_coord(mode, base),
                     rand_coord(mode, base), f,
                     ($urandom_range(9) == 0) ? csai_pkg::t_tag'(3)
                                              : csai_pkg::t_tag'($urandom_range(2)));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_points.size() != 0);
    endtask

    task automatic write_tension(logic [FB+1:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tension_q = v;
    endtask

    initial begin
        logic [FB+1:0] phase_tension[6];
        phase_tension = '{18'd0, 18'd131072, 18'h3ffff, 18'd65536, 18'd0, 18'd32768};
        phase_tension[4] = 18'($urandom_range(0, (1 << (FB + 2)) - 1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items at the reset tension
        add_item('0, '0, '0, '0, '0, 2'd0);
        add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, '0, 2'd1);
        add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                 17'(1 << FB), 2'd2);
        add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                 17'(1 << (FB - 1)), 2'd3);
        add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, 17'd1, 2'd0);
        add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                 17'((1 << FB) - 1), 2'd1);
        // fraction above one clamps
        add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                 17'((1 << FB) + 1), 2'd2);
        add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                 '1, 2'd0);
        // saturation high and low
        add_item(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                 17'(1 << (FB - 1)), 2'd0);
        add_item(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                 17'(1 << (FB - 1)), 2'd1);
        add_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 17'd21845, 2'd2);
        add_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 17'd43690, 2'd3);
        add_item('1, '1, '1, '1, '1, 2'd3);
        add_item(32'sh8000_0000, '0, 32'sh7fff_ffff, '0, 17'd16384, 2'd1);
        add_item('0, 32'sh7fff_ffff, '0, 32'sh8000_0000, 17'd49152, 2'd2);
        add_item(-32'sh0003_8000, 32'sh0000_4000, -32'sh0001_0000, 32'sh0005_2000,
                 17'd12345, 2'd0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            write_tension(phase_tension[ph]);
            @(negedge i_clk);
            send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 71 : 0;
            recv_idle_pct = (ph < 2) ? 71 : (ph < 4) ? 30 : 0;
            phase_no = ph;
            if (ph == 5) begin
                // sender pauses until the pipeline has drained
                add_random_items(PHASE_LEN / 2);
                wait_drained();
                add_random_items(PHASE_LEN - PHASE_LEN / 2);
            end else begin
                add_random_items(PHASE_LEN);
            end
            wait_drained();
        end

        repeat (3 * csai_pkg::STAGES) @(posedge i_clk);
        if (expected_points.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_points.size()));
        if (errors == 0) begin
            $display("PASS cardinal_spline_axis_interp_unit");
        end else begin
            $display("FAIL cardinal_spline_axis_interp_unit");
        end
        $finish;
    end
endmodule

>>> sim.f
design/csai_pkg.sv
design/cardinal_spline_axis_interp_unit.sv
tb/sv/cardinal_spline_axis_interp_unit_test.sv
